FILE: sv/robb_pkg.sv
// robb_pkg: register indexes and fixed field widths for the ray / oriented box slab test.
// Used by ray_obb_slab_intersection; depends on nothing.
package robb_pkg;

   localparam int CFG_WIDTH   = 48;   // width of one configuration register
   localparam int TOL_WIDTH   = 16;   // zero_tolerance width
   localparam int AXIS_WIDTH  = 16;   // one Q1.14 axis component
   localparam int DIR_WIDTH   = 16;   // one Q1.14 direction component
   localparam int ORG_WIDTH   = 16;   // one Q8.8 origin field on the port
   localparam int CSR_IDX_WIDTH = 3;

   localparam int HALF_SHIFT  = 14;   // Q.8 half extent to Q.22
   localparam int DIST_SHIFT  = 22;   // Q.22 / Q.28 to Q16.16
   localparam int TOL_SHIFT   = 14;   // tolerance to Q.28

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_BOX_CENTER   = 3'd0,
      REG_HALF_EXTENTS = 3'd1,
      REG_AXIS_FIRST   = 3'd2,
      REG_AXIS_SECOND  = 3'd3,
      REG_AXIS_THIRD   = 3'd4,
      REG_ZERO_TOL     = 3'd5
   } reg_index_type;

endpackage

FILE: sv/ray_obb_slab_intersection.sv
// ray_obb_slab_intersection: pipelined ray / oriented box slab test with a
// restoring divider that resolves one quotient bit per stage. Depends on robb_pkg.
//
//   channel | direction | handshake              | content
//   req     | in        | req_tvalid/req_tready  | tdata: origin x,y,z, dir x,y,z
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata: distance, tuser: hit
//   csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One ray enters per cycle while req_tready is high. The ray passes QW + 7
// register stages, QW = COORD_WIDTH + 41 (64 stages at the default): four stages
// of projection, one divider stage per quotient bit, two stages of slab reduction
// and the output register.
// Reset clears all valid bits and loads the register reset values.
// A skid register behind the output catches the pipeline's item when rsp is held,
// so the pipeline keeps moving; req_tready drops only while the skid register is full.
module ray_obb_slab_intersection #(
   parameter int COORD_WIDTH = 16,
   parameter int DIST_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // origin_x[15:0], origin_y[31:16], origin_z[47:32], dir_x[63:48],
   // dir_y[79:64], dir_z[95:80]
   input  logic [6*robb_pkg::ORG_WIDTH-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // distance[DIST_WIDTH-2:0], zero padded to whole bytes
   output logic [((DIST_WIDTH-1+7)/8)*8-1:0] rsp_tdata,
   // hit[0]
   output logic [0:0] rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [robb_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [robb_pkg::CFG_WIDTH-1:0] csr_data
);

   localparam int AXW  = robb_pkg::AXIS_WIDTH;
   localparam int PW   = COORD_WIDTH + 1;          // centre minus origin
   localparam int EPW  = AXW + PW;                 // one term of e
   localparam int EW   = EPW + 2;                  // e
   localparam int FPW  = AXW + robb_pkg::DIR_WIDTH; // one term of f
   localparam int FW   = FPW + 2;                  // f
   localparam int SW   = COORD_WIDTH + robb_pkg::HALF_SHIFT;
   localparam int ESW  = EW + 1;                   // e +/- s
   localparam int QW   = ESW - 1 + robb_pkg::DIST_SHIFT; // numerator / quotient
   localparam int DW   = FW - 1;                   // |f|
   localparam int TW   = QW + 2;                   // signed slab distance
   localparam int OW   = DIST_WIDTH - 1;
   localparam int TDW  = ((DIST_WIDTH - 1 + 7) / 8) * 8;
   localparam int XW   = COORD_WIDTH + robb_pkg::CFG_WIDTH;

   localparam logic signed [TW-1:0] T_LOW  = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] T_HIGH = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0] D_MAX  =
      signed'({{(TW-OW){1'b0}}, {OW{1'b1}}});

   typedef struct packed {
      logic [2:0]          par;     // slab parallel to ray
      logic [2:0]          pmiss;   // parallel slab and origin outside it
      logic [5:0]          qneg;    // quotient negative
      logic [2:0][DW-1:0]  div;     // |f| per slab
   } ctl_type;

   // ---------------- configuration ----------------
   logic [robb_pkg::CFG_WIDTH-1:0] center_ff, half_ff, ax0_ff, ax1_ff, ax2_ff;
   logic [robb_pkg::TOL_WIDTH-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= '0;
         ax0_ff    <= '0;
         ax1_ff    <= '0;
         ax2_ff    <= '0;
         tol_ff    <= robb_pkg::TOL_WIDTH'(1);
      end else if (csr_valid) begin
         case (csr_index)
            robb_pkg::REG_BOX_CENTER:   center_ff <= csr_data;
            robb_pkg::REG_HALF_EXTENTS: half_ff   <= csr_data;
            robb_pkg::REG_AXIS_FIRST:   ax0_ff    <= csr_data;
            robb_pkg::REG_AXIS_SECOND:  ax1_ff    <= csr_data;
            robb_pkg::REG_AXIS_THIRD:   ax2_ff    <= csr_data;
            robb_pkg::REG_ZERO_TOL:     tol_ff    <= csr_data[robb_pkg::TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic [XW-1:0] center_x, half_x;
   assign center_x = {{COORD_WIDTH{1'b0}}, center_ff};
   assign half_x   = {{COORD_WIDTH{1'b0}}, half_ff};

   logic signed [2:0][2:0][AXW-1:0] axis;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         axis[0][k] = ax0_ff[k*AXW +: AXW];
         axis[1][k] = ax1_ff[k*AXW +: AXW];
         axis[2][k] = ax2_ff[k*AXW +: AXW];
      end
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic skid_valid_ff;
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // ---------------- stage A: centre minus origin ----------------
   logic                        va_ff;
   logic signed [2:0][PW-1:0]   p_ff, p_in;
   logic signed [2:0][robb_pkg::DIR_WIDTH-1:0] d_ff, d_in;

   always_comb begin
      logic [COORD_WIDTH+robb_pkg::ORG_WIDTH-1:0] ox;
      logic signed [COORD_WIDTH-1:0] c, o;
      for (int k = 0; k < 3; k++) begin
         ox = {{COORD_WIDTH{1'b0}},
               req_tdata[k*robb_pkg::ORG_WIDTH +: robb_pkg::ORG_WIDTH]};
         o  = signed'(ox[COORD_WIDTH-1:0]);
         c  = signed'(center_x[k*COORD_WIDTH +: COORD_WIDTH]);
         p_in[k] = PW'(c) - PW'(o);
         d_in[k] = signed'(req_tdata[(3+k)*robb_pkg::ORG_WIDTH +: robb_pkg::DIR_WIDTH]);
      end
   end

   // ---------------- stage B: axis products ----------------
   logic                              vb_ff;
   logic signed [2:0][2:0][EPW-1:0]   pe_ff, pe_in;
   logic signed [2:0][2:0][FPW-1:0]   pf_ff, pf_in;

   // elements of a packed array are unsigned, so cast each back to signed
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            pe_in[i][k] = EPW'(signed'(axis[i][k])) * EPW'(signed'(p_ff[k]));
            pf_in[i][k] = FPW'(signed'(axis[i][k])) * FPW'(signed'(d_ff[k]));
         end
      end
   end

   // ---------------- stage C: projections ----------------
   logic                        vc_ff;
   logic signed [2:0][EW-1:0]   e_ff, e_in;
   logic signed [2:0][FW-1:0]   f_ff, f_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_in[i] = EW'(signed'(pe_ff[i][0])) + EW'(signed'(pe_ff[i][1]))
                 + EW'(signed'(pe_ff[i][2]));
         f_in[i] = FW'(signed'(pf_ff[i][0])) + FW'(signed'(pf_ff[i][1]))
                 + FW'(signed'(pf_ff[i][2]));
      end
   end

   // ---------------- stage D: numerators, divisors, parallel test ----------------
   logic          v_ff   [QW+1];
   ctl_type       ctl_ff [QW+1];
   logic [5:0][QW-1:0] nq_ff  [QW+1];
   logic [5:0][DW-1:0] rem_ff [QW+1];
   ctl_type       ctl_in;
   logic [5:0][QW-1:0] nq_in;

   always_comb begin
      logic signed [ESW-1:0] s, esp, esm;
      logic [ESW-1:0] mp, mm;
      logic [DW-1:0] fm;
      logic [DW-1:0] tol_s;
      tol_s = DW'({tol_ff, {robb_pkg::TOL_SHIFT{1'b0}}});
      for (int i = 0; i < 3; i++) begin
         s   = signed'(ESW'({half_x[i*COORD_WIDTH +: COORD_WIDTH],
                             {robb_pkg::HALF_SHIFT{1'b0}}}));
         esp = ESW'(signed'(e_ff[i])) + s;
         esm = ESW'(signed'(e_ff[i])) - s;
         mp  = esp[ESW-1] ? ESW'(-esp) : esp;
         mm  = esm[ESW-1] ? ESW'(-esm) : esm;
         nq_in[2*i]   = {mp[ESW-2:0], {robb_pkg::DIST_SHIFT{1'b0}}};
         nq_in[2*i+1] = {mm[ESW-2:0], {robb_pkg::DIST_SHIFT{1'b0}}};
         fm  = f_ff[i][FW-1] ? DW'(-f_ff[i]) : DW'(f_ff[i]);
         ctl_in.div[i]       = fm;
         ctl_in.qneg[2*i]    = esp[ESW-1] ^ f_ff[i][FW-1];
         ctl_in.qneg[2*i+1]  = esm[ESW-1] ^ f_ff[i][FW-1];
         ctl_in.par[i]       = fm <= tol_s;
         ctl_in.pmiss[i]     = ctl_in.par[i] && (esp[ESW-1] || (esm > 0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         va_ff   <= req_tvalid;
         vb_ff   <= va_ff;
         vc_ff   <= vb_ff;
         v_ff[0] <= vc_ff;
      end
      if (adv) begin
         p_ff      <= p_in;
         d_ff      <= d_in;
         pe_ff     <= pe_in;
         pf_ff     <= pf_in;
         e_ff      <= e_in;
         f_ff      <= f_in;
         ctl_ff[0] <= ctl_in;
         nq_ff[0]  <= nq_in;
         rem_ff[0] <= '0;
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   for (genvar g = 0; g < QW; g++) begin : g_div
      logic [5:0][QW-1:0] nq_in_s;
      logic [5:0][DW-1:0] rem_in_s;

      always_comb begin
         logic [DW:0] trial;
         logic [DW:0] dvx;
         for (int j = 0; j < 6; j++) begin
            trial = {rem_ff[g][j], nq_ff[g][j][QW-1]};
            dvx   = {1'b0, ctl_ff[g].div[j/2]};
            if (trial >= dvx) begin
               rem_in_s[j] = DW'(trial - dvx);
               nq_in_s[j]  = {nq_ff[g][j][QW-2:0], 1'b1};
            end else begin
               rem_in_s[j] = trial[DW-1:0];
               nq_in_s[j]  = {nq_ff[g][j][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (adv) begin
            ctl_ff[g+1] <= ctl_ff[g];
            nq_ff[g+1]  <= nq_in_s;
            rem_ff[g+1] <= rem_in_s;
         end
      end
   end

   // ---------------- stage E: signed slab bounds ----------------
   logic                       ve_ff;
   logic signed [2:0][TW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [2:0]                 pmiss_e_ff;

   always_comb begin
      logic signed [TW-1:0] t1, t2;
      for (int i = 0; i < 3; i++) begin
         t1 = ctl_ff[QW].qneg[2*i]   ? -TW'(nq_ff[QW][2*i])   : TW'(nq_ff[QW][2*i]);
         t2 = ctl_ff[QW].qneg[2*i+1] ? -TW'(nq_ff[QW][2*i+1]) : TW'(nq_ff[QW][2*i+1]);
         if (ctl_ff[QW].par[i]) begin
            lo_in[i] = T_LOW;
            hi_in[i] = T_HIGH;
         end else if (t1 < t2) begin
            lo_in[i] = t1;
            hi_in[i] = t2;
         end else begin
            lo_in[i] = t2;
            hi_in[i] = t1;
         end
      end
   end

   // ---------------- stage F: reduce over slabs ----------------
   logic                  vf_ff;
   logic signed [TW-1:0]  tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic                  pmiss_f_ff;

   always_comb begin
      tmin_in = lo_ff[0];
      tmax_in = hi_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (signed'(lo_ff[i]) > tmin_in) tmin_in = lo_ff[i];
         if (signed'(hi_ff[i]) < tmax_in) tmax_in = hi_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= v_ff[QW];
         vf_ff <= ve_ff;
      end
      if (adv) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         pmiss_e_ff <= ctl_ff[QW].pmiss;
         tmin_ff    <= tmin_in;
         tmax_ff    <= tmax_in;
         pmiss_f_ff <= |pmiss_e_ff;
      end
   end

   // ---------------- result, output register and skid ----------------
   logic            res_hit;
   logic [OW-1:0]   res_dist;

   always_comb begin
      logic signed [TW-1:0] t;
      logic miss;
      miss = pmiss_f_ff || tmax_ff[TW-1] || (tmin_ff > tmax_ff);
      t    = tmin_ff[TW-1] ? tmax_ff : tmin_ff;
      if (t > D_MAX) t = D_MAX;
      res_hit  = !miss;
      res_dist = miss ? '0 : t[OW-1:0];
   end

   logic            out_valid_ff, skid_hit_ff, out_hit_ff;
   logic [OW-1:0]   out_dist_ff, skid_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         // drain skid first, else take the pipeline's item
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= vf_ff;
         end
      end else if (vf_ff) begin
         skid_valid_ff <= 1'b1;
      end

      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_hit_ff  <= skid_hit_ff;
            out_dist_ff <= skid_dist_ff;
         end else begin
            out_hit_ff  <= res_hit;
            out_dist_ff <= res_dist;
         end
      end else if (!skid_valid_ff) begin
         skid_hit_ff  <= res_hit;
         skid_dist_ff <= res_dist;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = TDW'(out_dist_ff);
   assign rsp_tuser[0] = out_hit_ff;

endmodule

FILE: tb/sv/ray_obb_slab_intersection_tb.sv
// Testbench for ray_obb_slab_intersection: drives rays and box settings, predicts
// hit and distance per ray in a scoreboard class. Depends on robb_pkg and the block.
`timescale 1ns / 100ps

module ray_obb_slab_intersection_tb;

   localparam int CW = 16;
   localparam int DW = 32;
   localparam longint DIST_SAT = (64'sd1 <<< (DW - 1)) - 1;
   localparam int LATENCY = CW + 41 + 7;

   typedef struct packed {
      logic             hit;
      logic [DW-2:0]    distance;
   } hit_type;

   class ray_box_scoreboard;
      logic [robb_pkg::CFG_WIDTH-1:0] center, half;
      logic [robb_pkg::CFG_WIDTH-1:0] axis [3];
      logic [robb_pkg::TOL_WIDTH-1:0] tol;
      hit_type pending [$];
      int errors;
      int rays, hits;

      function void reset_regs();
         center = '0; half = '0;
         axis[0] = '0; axis[1] = '0; axis[2] = '0;
         tol = 16'd1;
      endfunction

      function void write_reg(robb_pkg::reg_index_type idx,
                              logic [robb_pkg::CFG_WIDTH-1:0] value);
         case (idx)
            robb_pkg::REG_BOX_CENTER:   center = value;
            robb_pkg::REG_HALF_EXTENTS: half = value;
            robb_pkg::REG_AXIS_FIRST:   axis[0] = value;
            robb_pkg::REG_AXIS_SECOND:  axis[1] = value;
            robb_pkg::REG_AXIS_THIRD:   axis[2] = value;
            robb_pkg::REG_ZERO_TOL:     tol = value[robb_pkg::TOL_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void note_ray(logic [95:0] ray);
         longint p [3], d [3];
         longint tmin, tmax, e, f, s, a, t1, t2, lo, hi, t, lim;
         bit miss;
         hit_type r;
         tmin = 64'sh8000_0000_0000_0000;
         tmax = 64'sh7fff_ffff_ffff_ffff;
         lim = longint'(tol) * 16384;
         miss = 0;
         for (int k = 0; k < 3; k++) begin
            p[k] = longint'($signed(center[k*CW +: CW])) - longint'($signed(ray[k*16 +: CW]));
            d[k] = longint'($signed(ray[48 + k*16 +: 16]));
         end
         for (int i = 0; i < 3; i++) begin
            e = 0; f = 0;
            for (int k = 0; k < 3; k++) begin
               a = longint'($signed(axis[i][k*16 +: 16]));
               e += a * p[k];
               f += a * d[k];
            end
            s = longint'(half[i*CW +: CW]) * 16384;
            if ((f < 0 ? -f : f) <= lim) begin
               if (e < -s || e > s) miss = 1;
               continue;
            end
            t1 = ((e + s) * 4194304) / f;
            t2 = ((e - s) * 4194304) / f;
            lo = t1 < t2 ? t1 : t2;
            hi = t1 < t2 ? t2 : t1;
            if (lo > tmin) tmin = lo;
            if (hi < tmax) tmax = hi;
         end
         if (!miss && (tmax < 0 || tmin > tmax)) miss = 1;
         if (miss) r = '0;
         else begin
            t = tmin < 0 ? tmax : tmin;
            if (t > DIST_SAT) t = DIST_SAT;
            r.hit = 1;
            r.distance = t[DW-2:0];
         end
         pending.insert(pending.size(), r);
         rays++;
      endfunction

      function void check_result(logic [31:0] data, logic hit_bit);
         hit_type x;
         if (pending.size() == 0) begin
            $error("result with no ray outstanding");
            errors++;
            return;
         end
         x = pending.pop_front();
         if (x.hit) hits++;
         if (hit_bit !== x.hit) begin
            $error("hit: expected %0d, actual %0d", x.hit, hit_bit);
            errors++;
         end
         if (data[DW-2:0] !== x.distance) begin
            $error("distance: expected %0h, actual %0h", x.distance, data[DW-2:0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [95:0] req_tdata = '0;
   logic [31:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic [robb_pkg::CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [robb_pkg::CFG_WIDTH-1:0] csr_data = '0;
   bit calm = 0;
   int cfg_writes = 0;

   ray_box_scoreboard board = new();

   ray_obb_slab_intersection #(.COORD_WIDTH(CW), .DIST_WIDTH(DW)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 13);
   endfunction

   // drain the result channel with random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser[0]);
         rsp_tready <= !idle_now();
      end
   end

   // valid stays high after the write; the next ray drops it
   task automatic write_reg(robb_pkg::reg_index_type idx,
                            logic [robb_pkg::CFG_WIDTH-1:0] value);
      csr_valid <= 1; csr_index <= idx; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      cfg_writes++;
   endtask

   // valid stays high after the item; an idle cycle or settle drops it
   task automatic send_ray(logic [95:0] ray);
      csr_valid <= 0;
      while (idle_now()) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= ray;
      do @(posedge clock); while (!req_tready);
      board.note_ray(ray);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [15:0] unit_part(int sel);
      case (sel)
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [95:0] random_ray(bit aimed);
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      if (aimed)
         // aim the origin near the centre and zero some direction components
         for (int k = 0; k < 3; k++) begin
            r[k*16 +: 16] = 16'($signed(board.center[k*16 +: 16])
                            + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
            if ($urandom_range(3) == 0) r[48 + k*16 +: 16] = 16'd0;
         end
      return r;
   endfunction

   task automatic random_box(int style);
      logic [47:0] c, h;
      c = 48'({$urandom, $urandom});
      h = 48'({$urandom, $urandom});
      if (style == 0) begin
         c = {16'($urandom_range(0,2047)), 16'($urandom_range(0,2047)),
              16'($urandom_range(0,2047))};
         h = {16'($urandom_range(0,4095)), 16'($urandom_range(0,4095)),
              16'($urandom_range(0,4095))};
      end
      write_reg(robb_pkg::REG_BOX_CENTER, c);
      write_reg(robb_pkg::REG_HALF_EXTENTS, h);
      if (style == 0) begin
         write_reg(robb_pkg::REG_AXIS_FIRST,  {16'd0, 16'd0, 16'sd16384});
         write_reg(robb_pkg::REG_AXIS_SECOND, {16'd0, 16'sd16384, 16'd0});
         write_reg(robb_pkg::REG_AXIS_THIRD,  {16'sd16384, 16'd0, 16'd0});
      end else begin
         write_reg(robb_pkg::REG_AXIS_FIRST,
                   {unit_part($urandom_range(3)), unit_part(3), unit_part(3)});
         write_reg(robb_pkg::REG_AXIS_SECOND, 48'({$urandom, $urandom}));
         write_reg(robb_pkg::REG_AXIS_THIRD,
                   {unit_part($urandom_range(3)), unit_part(2), unit_part(3)});
      end
      write_reg(robb_pkg::REG_ZERO_TOL,
                48'(style == 2 ? 16'($urandom) : 16'($urandom_range(0, 4))));
   endtask

   initial begin
      board.reset_regs();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset state: every slab parallel, e = 0, so rays hit at saturation
      send_ray('0);
      send_ray({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      settle();
      write_reg(robb_pkg::REG_BOX_CENTER, '0);
      write_reg(robb_pkg::REG_HALF_EXTENTS, {16'h0100, 16'h0100, 16'h0100});
      write_reg(robb_pkg::REG_AXIS_FIRST,  {16'd0, 16'd0, 16'sd16384});
      write_reg(robb_pkg::REG_AXIS_SECOND, {16'd0, 16'sd16384, 16'd0});
      write_reg(robb_pkg::REG_AXIS_THIRD,  {16'sd16384, 16'd0, 16'd0});
      write_reg(robb_pkg::REG_ZERO_TOL, 48'd0);
      // hit from outside, origin inside, behind, parallel in and out, extremes
      send_ray({16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, -16'sh0500});
      send_ray({16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0});
      send_ray({16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'sh0500});
      send_ray({16'd0, 16'sd16384, 16'd0, 16'd0, 16'h0050, -16'sh0500});
      send_ray({16'd0, 16'sd16384, 16'd0, 16'd0, 16'h0500, -16'sh0500});
      send_ray({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
      send_ray({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
      send_ray({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, -16'sh0500});
      settle();
      write_reg(robb_pkg::REG_ZERO_TOL, 48'hffff);
      write_reg(robb_pkg::REG_HALF_EXTENTS, {48{1'b1}});
      send_ray({16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, -16'sh0500});
      send_ray({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
      settle();
      write_reg(robb_pkg::REG_BOX_CENTER, {48{1'b1}});
      write_reg(robb_pkg::REG_ZERO_TOL, 48'd1);
      send_ray({$urandom, $urandom, $urandom});
      settle();
      for (int ph = 0; ph < 22; ph++) begin
         calm = (ph == 5 || ph == 6);
         random_box(ph % 3);
         for (int n = 0; n < 75; n++) send_ray(random_ray($urandom_range(9) < 7));
         settle();
      end
      calm = 0;
      $display("Covered %0d rays (%0d hits) over %0d register writes.",
               board.rays, board.hits, cfg_writes);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
